>>> rtl/core/bbs_pkg.sv
package bbs_pkg;

    // Field and register widths
    localparam int WLEN_W     = 7;
    localparam int MULT_W     = 12;
    localparam int WEIGHT_W   = 16;
    localparam int SCORE_W    = 32;
    localparam int BAND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Q4.8 multiple squared gives 16 fraction bits
    localparam int FRAC_SHIFT = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_MULT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_MULT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT        = 2'd3;

    // Band crossing codes
    localparam logic [BAND_W-1:0] BAND_INSIDE = 2'd0;
    localparam logic [BAND_W-1:0] BAND_ABOVE  = 2'd1;
    localparam logic [BAND_W-1:0] BAND_BELOW  = 2'd2;

    // Products run on the shared shift-add multiplier, in this order
    typedef enum logic [1:0] {
        MOP_NSQ = 2'd0,   // n * sum of squares
        MOP_SS  = 2'd1,   // sum * sum
        MOP_MAG = 2'd2,   // |n*price - sum| squared
        MOP_MM  = 2'd3    // variance term * mult^2
    } t_mul_op;

    typedef struct packed {
        logic     accept;
        logic     rd_issue;
        logic     mul_load;
        logic     mul_step;
        logic     mul_store;
        t_mul_op  mul_op;
        logic     div_load;
        logic     div_step;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic rd_last;
        logic pipe_busy;
        logic mul_done;
        logic div_done;
        logic out_free;
    } t_dp_sts;

endpackage

>>> rtl/core/bbs_ctrl.sv
module bbs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output bbs_pkg::t_dp_cmd  o_cmd,
    input  bbs_pkg::t_dp_sts  i_sts
);
    import bbs_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_ACC   = 7'b0000010,
        S_DRAIN = 7'b0000100,
        S_MLOAD = 7'b0001000,
        S_MRUN  = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    t_state  r_state, n_state;
    t_mul_op r_op, n_op;

    // Sequence one beat: window sweep, four products, mean division, output
    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        o_cmd         = '0;
        o_cmd.mul_op  = r_op;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.rd_issue = 1'b1;
                if (i_sts.rd_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_op    = MOP_NSQ;
                    n_state = S_MLOAD;
                end
            end
            S_MLOAD: begin
                o_cmd.mul_load = 1'b1;
                n_state        = S_MRUN;
            end
            S_MRUN: begin
                if (i_sts.mul_done) begin
                    o_cmd.mul_store = 1'b1;
                    unique case (r_op)
                        MOP_NSQ: begin
                            n_op    = MOP_SS;
                            n_state = S_MLOAD;
                        end
                        MOP_SS: begin
                            n_op    = MOP_MAG;
                            n_state = S_MLOAD;
                        end
                        MOP_MAG: begin
                            n_op    = MOP_MM;
                            n_state = S_MLOAD;
                        end
                        MOP_MM: begin
                            o_cmd.div_load = 1'b1;
                            n_state        = S_DIV;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end else begin
                    o_cmd.mul_step = 1'b1;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= MOP_NSQ;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

endmodule

>>> rtl/core/bbs_dp.sv
module bbs_dp #(
    parameter int WINDOW_MAX = 64,
    parameter int PRICE_BITS = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  bbs_pkg::t_dp_cmd                       i_cmd,
    output bbs_pkg::t_dp_sts                       o_sts,
    input  logic        [bbs_pkg::WLEN_W-1:0]      i_window_length,
    input  logic        [bbs_pkg::MULT_W-1:0]      i_upper_mult,
    input  logic        [bbs_pkg::MULT_W-1:0]      i_lower_mult,
    input  logic signed [bbs_pkg::WEIGHT_W-1:0]    i_weight,
    input  logic        [PRICE_BITS-1:0]           i_price,
    input  logic signed [bbs_pkg::SCORE_W-1:0]     i_prior_score,
    input  logic                                   i_last_sample,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [bbs_pkg::SCORE_W-1:0]     o_updated_score,
    output logic        [bbs_pkg::BAND_W-1:0]      o_band_signal,
    output logic        [PRICE_BITS-1:0]           o_window_mean
);
    import bbs_pkg::*;

    localparam int NB     = $clog2(WINDOW_MAX + 1);
    localparam int PTR_W  = $clog2(WINDOW_MAX);
    localparam int SUM_W  = PRICE_BITS + NB;
    localparam int SQ_W   = 2 * PRICE_BITS + NB;
    localparam int VAR_W  = 2 * SUM_W;
    localparam int MM_W   = 2 * MULT_W;
    localparam int PROD_W = VAR_W + MM_W;
    localparam int LHS_W  = 2 * SUM_W + FRAC_SHIFT;
    localparam int B_W    = (SUM_W > MM_W) ? SUM_W : MM_W;
    localparam int LW     = (NB > WLEN_W) ? NB : WLEN_W;
    localparam int DCNT_W = $clog2(SUM_W + 1);

    // Sample ring
    logic [PRICE_BITS-1:0]     r_ring [WINDOW_MAX];

    // Series state and sweep control
    logic [PTR_W-1:0]          r_wp, r_rd_addr;
    logic [NB-1:0]             r_fill, r_n, r_rd_left;
    logic                      r_v1, r_v2;

    // Item payload and sums
    logic [PRICE_BITS-1:0]     r_price;
    logic signed [SCORE_W-1:0] r_score;
    logic [PRICE_BITS-1:0]     r_rd_data;
    logic [2*PRICE_BITS-1:0]   r_sq_term;
    logic [SUM_W-1:0]          r_sum, r_np;
    logic [SQ_W-1:0]           r_sq;

    // Shared multiplier and band test
    logic [PROD_W-1:0]         r_ma, r_acc;
    logic [B_W-1:0]            r_mb;
    logic [VAR_W-1:0]          r_var;
    logic [LHS_W-1:0]          r_lhs;
    logic                      r_up, r_gt;

    // Mean divider
    logic [SUM_W-1:0]          r_dq;
    logic [NB-1:0]             r_drem;
    logic [DCNT_W-1:0]         r_dcnt;

    // Output slot
    logic                      r_out_vld;
    logic signed [SCORE_W-1:0] r_out_score;
    logic [BAND_W-1:0]         r_out_band;
    logic [PRICE_BITS-1:0]     r_out_mean;

    logic [LW-1:0]             len_ext, len_c;
    logic [NB-1:0]             fill_new, n_new;
    logic [PTR_W-1:0]          wp_inc, rd_dec;
    logic                      up_now;
    logic [SUM_W-1:0]          mag;
    logic [MULT_W-1:0]         mult_sel;
    logic [MM_W-1:0]           mm;
    logic [NB:0]               trial;
    logic                      ge;
    logic [BAND_W-1:0]         band;
    logic signed [SCORE_W:0]   s_ext, w_ext, s_new;
    logic signed [SCORE_W-1:0] s_sat;

    // Window size for this beat: clamp the length register, limit by fill
    always_comb begin
        len_ext  = LW'(i_window_length);
        if (len_ext == '0) begin
            len_c = LW'(1);
        end else if (len_ext > LW'(WINDOW_MAX)) begin
            len_c = LW'(WINDOW_MAX);
        end else begin
            len_c = len_ext;
        end
        fill_new = (r_fill < NB'(WINDOW_MAX)) ? r_fill + 1'b1 : r_fill;
        n_new    = (LW'(fill_new) < len_c) ? fill_new : NB'(len_c);
    end

    assign wp_inc = (r_wp == PTR_W'(WINDOW_MAX - 1)) ? '0 : r_wp + 1'b1;
    assign rd_dec = (r_rd_addr == '0) ? PTR_W'(WINDOW_MAX - 1) : r_rd_addr - 1'b1;

    // Deviation of n*price from the sum, and the band multiple to square
    assign up_now   = (r_np > r_sum);
    assign mag      = up_now ? r_np - r_sum : r_sum - r_np;
    assign mult_sel = r_up ? i_upper_mult : i_lower_mult;
    assign mm       = MM_W'(mult_sel) * MM_W'(mult_sel);

    // Restoring division step
    assign trial = {r_drem, r_dq[SUM_W-1]};
    assign ge    = (trial >= {1'b0, r_n});

    // Score update with saturation
    always_comb begin
        band  = r_gt ? (r_up ? BAND_ABOVE : BAND_BELOW) : BAND_INSIDE;
        s_ext = (SCORE_W + 1)'(r_score);
        w_ext = (SCORE_W + 1)'(i_weight);
        case (band)
            BAND_ABOVE: s_new = s_ext - w_ext;
            BAND_BELOW: s_new = s_ext + w_ext;
            default:    s_new = s_ext;
        endcase
        if (s_new[SCORE_W] != s_new[SCORE_W-1]) begin
            s_sat = s_new[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}}
                                   : {1'b0, {(SCORE_W-1){1'b1}}};
        end else begin
            s_sat = s_new[SCORE_W-1:0];
        end
    end

    // Write the new sample, read the window back one entry a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ring[r_wp] <= i_price;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_ring[r_rd_addr];
        end
    end

    // Series pointers and sweep valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_fill    <= '0;
            r_rd_left <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_rd_left <= n_new;
                if (i_last_sample) begin
                    r_wp   <= '0;
                    r_fill <= '0;
                end else begin
                    r_wp   <= wp_inc;
                    r_fill <= fill_new;
                end
            end else if (i_cmd.rd_issue) begin
                r_rd_left <= r_rd_left - 1'b1;
            end
            r_v1 <= i_cmd.rd_issue;
            r_v2 <= r_v1;
        end
    end

    // Capture the beat and accumulate sum and sum of squares
    always_ff @(posedge i_clk) begin
        r_sq_term <= (2*PRICE_BITS)'(r_rd_data) * (2*PRICE_BITS)'(r_rd_data);
        r_np      <= SUM_W'(r_n) * SUM_W'(r_price);
        if (i_cmd.accept) begin
            r_price   <= i_price;
            r_score   <= i_prior_score;
            r_n       <= n_new;
            r_rd_addr <= r_wp;
            r_sum     <= '0;
            r_sq      <= '0;
        end else begin
            if (i_cmd.rd_issue) begin
                r_rd_addr <= rd_dec;
            end
            if (r_v1) begin
                r_sum <= r_sum + SUM_W'(r_rd_data);
            end
            if (r_v2) begin
                r_sq <= r_sq + SQ_W'(r_sq_term);
            end
        end
    end

    // Shift-add multiplier: one multiplier bit per cycle, stops when it runs out
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_load) begin
            r_acc <= '0;
            unique case (i_cmd.mul_op)
                MOP_NSQ: begin
                    r_ma <= PROD_W'(r_sq);
                    r_mb <= B_W'(r_n);
                end
                MOP_SS: begin
                    r_ma <= PROD_W'(r_sum);
                    r_mb <= B_W'(r_sum);
                end
                MOP_MAG: begin
                    r_ma <= PROD_W'(mag);
                    r_mb <= B_W'(mag);
                    r_up <= up_now;
                end
                MOP_MM: begin
                    r_ma <= PROD_W'(r_var);
                    r_mb <= B_W'(mm);
                end
                default: begin
                    r_ma <= '0;
                    r_mb <= '0;
                end
            endcase
        end else if (i_cmd.mul_step) begin
            if (r_mb[0]) begin
                r_acc <= r_acc + r_ma;
            end
            r_ma <= r_ma << 1;
            r_mb <= r_mb >> 1;
        end
        if (i_cmd.mul_store) begin
            unique case (i_cmd.mul_op)
                MOP_NSQ: r_var <= VAR_W'(r_acc);
                MOP_SS:  r_var <= r_var - VAR_W'(r_acc);
                MOP_MAG: r_lhs <= {r_acc[2*SUM_W-1:0], {FRAC_SHIFT{1'b0}}};
                MOP_MM:  r_gt  <= (PROD_W'(r_lhs) > r_acc);
                default: r_gt  <= 1'b0;
            endcase
        end
    end

    // Mean: one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_load) begin
            r_dcnt <= DCNT_W'(SUM_W);
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_dq   <= r_sum;
            r_drem <= '0;
        end else if (i_cmd.div_step) begin
            r_dq   <= {r_dq[SUM_W-2:0], ge};
            r_drem <= ge ? NB'(trial - {1'b0, r_n}) : NB'(trial);
        end
    end

    // Output slot: hold the result until the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_score <= s_sat;
            r_out_band  <= band;
            r_out_mean  <= r_dq[PRICE_BITS-1:0];
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_updated_score = r_out_score;
    assign o_band_signal   = r_out_band;
    assign o_window_mean   = r_out_mean;

    assign o_sts.rd_last   = (r_rd_left == NB'(1));
    assign o_sts.pipe_busy = r_v1 | r_v2;
    assign o_sts.mul_done  = (r_mb == '0);
    assign o_sts.div_done  = (r_dcnt == '0);
    assign o_sts.out_free  = !r_out_vld || i_out_ready;

    a_store_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mul_store |-> (r_mb == '0))
        else $error("product stored before multiplier finished");

    a_n_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |=> (r_n != '0) && (r_n <= NB'(WINDOW_MAX)))
        else $error("window size out of range");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mul_load |-> !(r_v1 || r_v2))
        else $error("multiply started while sums still accumulating");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |=> (r_drem < r_n))
        else $error("divider remainder not below divisor");

endmodule

>>> rtl/core/bollinger_band_signal_core.sv
// From accept to result valid a beat runs the window sweep over the n samples of the window
// in use, the four products on the shared shift-add multiplier, each stepped once per bit of
// its multiplier operand, and the bit-serial mean division over every bit of the sum.
// A new beat is accepted only after the previous result is loaded into the output slot, which
// waits while the previous result beat is untaken; the sweep, multiplier and divider set the pace.
// Reset (synchronous, active low) empties the series, clears control and loads the
// register defaults; ring contents are left as they are.
module bollinger_band_signal_core #(
    parameter  int WINDOW_MAX = 64,
    parameter  int PRICE_BITS = 24,
    localparam int IN_W  = ((PRICE_BITS + bbs_pkg::SCORE_W + 7) / 8) * 8,
    localparam int OUT_W = ((bbs_pkg::SCORE_W + bbs_pkg::BAND_W + PRICE_BITS + 7) / 8) * 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [IN_W-1:0]                  i_s_axis_tdata,  // price, prior_score
    input  logic                             i_s_axis_tlast,  // last_sample
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [OUT_W-1:0]                 o_m_axis_tdata,  // updated_score, band_signal, window_mean
    input  logic                             i_cfg_we,
    input  logic [bbs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bbs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bbs_pkg::*;

    logic [WLEN_W-1:0]          r_window_length;
    logic [MULT_W-1:0]          r_upper_mult, r_lower_mult;
    logic signed [WEIGHT_W-1:0] r_weight;

    t_dp_cmd                    cmd;
    t_dp_sts                    sts;
    logic signed [SCORE_W-1:0]  out_score;
    logic [BAND_W-1:0]          out_band;
    logic [PRICE_BITS-1:0]      out_mean;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WLEN_W'(20);
            r_upper_mult    <= MULT_W'(512);
            r_lower_mult    <= MULT_W'(512);
            r_weight        <= WEIGHT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WINDOW_LENGTH: r_window_length <= i_cfg_data[WLEN_W-1:0];
                CFG_UPPER_MULT:    r_upper_mult    <= i_cfg_data[MULT_W-1:0];
                CFG_LOWER_MULT:    r_lower_mult    <= i_cfg_data[MULT_W-1:0];
                CFG_WEIGHT:        r_weight        <= signed'(i_cfg_data[WEIGHT_W-1:0]);
                default:           r_weight        <= r_weight;
            endcase
        end
    end

    bbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    bbs_dp #(
        .WINDOW_MAX (WINDOW_MAX),
        .PRICE_BITS (PRICE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_window_length (r_window_length),
        .i_upper_mult    (r_upper_mult),
        .i_lower_mult    (r_lower_mult),
        .i_weight        (r_weight),
        .i_price         (i_s_axis_tdata[PRICE_BITS-1:0]),
        .i_prior_score   (signed'(i_s_axis_tdata[PRICE_BITS +: SCORE_W])),
        .i_last_sample   (i_s_axis_tlast),
        .o_out_valid     (o_m_axis_tvalid),
        .i_out_ready     (i_m_axis_tready),
        .o_updated_score (out_score),
        .o_band_signal   (out_band),
        .o_window_mean   (out_mean)
    );

    // Pack the result beat
    assign o_m_axis_tdata = OUT_W'({out_mean, out_band, out_score});

endmodule
